// ===== hdl/fixed_block_free_list_allocator_unit_assert.svh =====
// Assertion macros shared by the allocator checker.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH

// Implication that is checked only out of reset.
`define FBFL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Property that is checked at every edge, reset included.
`define FBFL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/fbfl_pkg.sv =====
// Shared constants and types of the fixed block free list allocator.
package fbfl_pkg;

  localparam int unsigned NUM_BLOCKS_DEF = 64;

  localparam int unsigned INDEX_FIELD_W = 6;
  localparam int unsigned COUNT_FIELD_W = 7;
  localparam int unsigned STATUS_FIELD_W = 2;

  localparam int unsigned INDEX_FIELD_VALUES = 2 ** INDEX_FIELD_W;

  typedef logic [STATUS_FIELD_W-1:0] status_t;

  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_EXHAUSTED = 2'd1;
  localparam status_t STATUS_UNDERFLOW = 2'd2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

endpackage

// ===== hdl/fixed_block_free_list_allocator_unit.sv =====
// Top level of the fixed block free list allocator.
//
//   Channel  Direction  Handshake          Word
//   in_      input      in_valid/in_stall  in_cmd, in_block_index
//   out_     output     out_valid/out_stall out_granted_index, out_status, out_in_use
//
// A free or a failed request is answered straight from S_IDLE; a successful
// allocate passes through S_POP as well, because the next link of the head comes
// from a registered read of the link memory at the head address. After reset the
// link memory is initialized by a sweep over all NUM_BLOCKS entries, during which
// in_stall stays high. The result word is registered; a new word is accepted in
// the cycle the previous result is taken.
module fixed_block_free_list_allocator_unit #(
  parameter int unsigned NUM_BLOCKS = fbfl_pkg::NUM_BLOCKS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_cmd,
  input  logic [fbfl_pkg::INDEX_FIELD_W-1:0]  in_block_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [fbfl_pkg::INDEX_FIELD_W-1:0]  out_granted_index,
  output fbfl_pkg::status_t                   out_status,
  output logic [fbfl_pkg::COUNT_FIELD_W-1:0]  out_in_use
);

  import fbfl_pkg::*;

  localparam int unsigned IDX_W = $clog2(NUM_BLOCKS);
  localparam int unsigned CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(NUM_BLOCKS);

  typedef enum logic {
    S_IDLE,
    S_POP
  } state_t;

  state_t                    state_r;
  state_t                    state_nxt;
  logic [IDX_W-1:0]          head_r;
  logic [IDX_W-1:0]          head_nxt;
  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          count_nxt;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic [INDEX_FIELD_W-1:0]  out_granted_r;
  logic [INDEX_FIELD_W-1:0]  out_granted_nxt;
  status_t                   out_status_r;
  status_t                   out_status_nxt;
  logic [COUNT_FIELD_W-1:0]  out_in_use_r;
  logic [COUNT_FIELD_W-1:0]  out_in_use_nxt;

  logic                      accept;
  logic                      ram_ready;
  logic                      ram_we;
  logic [IDX_W-1:0]          ram_rd_data;
  logic [IDX_W-1:0]          idx_mod;

  fbfl_link_ram #(
    .NUM_BLOCKS(NUM_BLOCKS),
    .IDX_W     (IDX_W)
  ) u_link_ram (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (ram_we),
    .wr_addr(idx_mod),
    .wr_data(head_r),
    .rd_addr(head_r),
    .rd_data(ram_rd_data),
    .ready  (ram_ready)
  );

  // Freed indices wrap around the pool size.
  always_comb begin
    idx_mod = '0;
    for (int k = 0; k < INDEX_FIELD_VALUES; k++) begin
      if (in_block_index == INDEX_FIELD_W'(k)) begin
        idx_mod = IDX_W'(k % NUM_BLOCKS);
      end
    end
  end

  assign in_stall = !ram_ready || (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign ram_we   = accept && (in_cmd == CMD_FREE) && (count_r != '0);

  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    count_nxt       = count_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_granted_nxt = out_granted_r;
    out_status_nxt  = out_status_r;
    out_in_use_nxt  = out_in_use_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_ALLOC) begin
            if (count_r == FULL_COUNT) begin
              out_valid_nxt   = 1'b1;
              out_granted_nxt = '0;
              out_status_nxt  = STATUS_EXHAUSTED;
              out_in_use_nxt  = COUNT_FIELD_W'(count_r);
            end else begin
              state_nxt = S_POP;
            end
          end else begin
            out_valid_nxt   = 1'b1;
            out_granted_nxt = '0;
            if (count_r == '0) begin
              out_status_nxt = STATUS_UNDERFLOW;
              out_in_use_nxt = '0;
            end else begin
              head_nxt       = idx_mod;
              count_nxt      = count_r - 1'b1;
              out_status_nxt = STATUS_OK;
              out_in_use_nxt = COUNT_FIELD_W'(count_r - 1'b1);
            end
          end
        end
      end
      S_POP: begin
        head_nxt        = ram_rd_data;
        count_nxt       = count_r + 1'b1;
        out_valid_nxt   = 1'b1;
        out_granted_nxt = INDEX_FIELD_W'(head_r);
        out_status_nxt  = STATUS_OK;
        out_in_use_nxt  = COUNT_FIELD_W'(count_r + 1'b1);
        state_nxt       = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_granted_r <= out_granted_nxt;
    out_status_r  <= out_status_nxt;
    out_in_use_r  <= out_in_use_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_granted_index = out_granted_r;
  assign out_status        = out_status_r;
  assign out_in_use        = out_in_use_r;

endmodule

// ===== hdl/fbfl_link_ram.sv =====
// Next-link memory of the free list with its initialization sweep.
module fbfl_link_ram #(
  parameter int unsigned NUM_BLOCKS = fbfl_pkg::NUM_BLOCKS_DEF,
  parameter int unsigned IDX_W      = $clog2(NUM_BLOCKS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [IDX_W-1:0] wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [IDX_W-1:0] rd_data,
  output logic             ready
);

  localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(NUM_BLOCKS - 1);

  logic [IDX_W-1:0] mem [NUM_BLOCKS];
  logic [IDX_W-1:0] clr_addr_r;
  logic [IDX_W-1:0] clr_addr_nxt;
  logic             ready_r;
  logic             ready_nxt;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_wdata;
  logic [IDX_W-1:0] rd_data_r;

  always_comb begin
    clr_addr_nxt = clr_addr_r;
    ready_nxt    = ready_r;
    if (!ready_r) begin
      if (clr_addr_r == LAST_ADDR) begin
        ready_nxt = 1'b1;
      end else begin
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
    end
  end

  always_comb begin
    if (!ready_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = (clr_addr_r == LAST_ADDR) ? '0 : clr_addr_r + 1'b1;
    end else begin
      mem_we    = wr_en;
      mem_waddr = wr_addr;
      mem_wdata = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      ready_r    <= 1'b0;
    end else begin
      clr_addr_r <= clr_addr_nxt;
      ready_r    <= ready_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;
  assign ready   = ready_r;

endmodule

// ===== hdl/fbfl_checker.sv =====
// Port-level checker of the allocator and its bind to the top level.
`include "fixed_block_free_list_allocator_unit_assert.svh"

module fbfl_checker #(
  parameter int unsigned NUM_BLOCKS = fbfl_pkg::NUM_BLOCKS_DEF
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic [fbfl_pkg::INDEX_FIELD_W-1:0] out_granted_index,
  input fbfl_pkg::status_t                  out_status,
  input logic [fbfl_pkg::COUNT_FIELD_W-1:0] out_in_use
);

  import fbfl_pkg::*;

  localparam logic [COUNT_FIELD_W-1:0] FULL_IN_USE = COUNT_FIELD_W'(NUM_BLOCKS);

  // The link memory sweep keeps the input stalled right after reset.
  `FBFL_ASSERT_ALWAYS(a_stall_after_reset, (!rst_n |=> in_stall), "input taken during init")
  `FBFL_ASSERT_IMP(a_exhausted_full, out_valid && out_status == STATUS_EXHAUSTED,
                   out_in_use == FULL_IN_USE, "exhausted with free blocks left")
  `FBFL_ASSERT_IMP(a_underflow_empty, out_valid && out_status == STATUS_UNDERFLOW,
                   out_in_use == '0, "underflow with blocks in use")
  `FBFL_ASSERT_IMP(a_fail_no_grant, out_valid && out_status != STATUS_OK,
                   out_granted_index == '0, "grant index on a failed request")
  `FBFL_ASSERT_IMP(a_status_code, out_valid,
                   out_status == STATUS_OK || out_status == STATUS_EXHAUSTED ||
                   out_status == STATUS_UNDERFLOW, "undefined status code")

endmodule

bind fixed_block_free_list_allocator_unit fbfl_checker #(
  .NUM_BLOCKS(NUM_BLOCKS)
) u_fbfl_checker (.*);
